// ----- sv/stq_pkg.sv -----
`default_nettype none
package stq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned TIME_W        = 64;
    localparam int unsigned ID_W          = 8;

    localparam logic [TIME_W-1:0] TIME_ALL_ONES = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_ARM      = 2'd0,
        KIND_WITHDRAW = 2'd1,
        KIND_REARM    = 2'd2,
        KIND_DRAIN    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   item_id;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] interval;
        logic              absolute;
        logic [TIME_W-1:0] now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_id;
        logic [TIME_W-1:0] out_deadline;
        logic              last;
    } out_item_t;

    // Command handed from the front end to the queue engine.
    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dl;
        logic [TIME_W-1:0] period;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dl;
        logic [TIME_W-1:0] period;
    } slot_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_BASE,
        F_ADD
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_INS_RD,
        B_INS_CMP,
        B_WD_RD,
        B_WD_CMP,
        B_SH_RD,
        B_SH_WR,
        B_DR_RD,
        B_DR_EMIT,
        B_EMIT
    } back_state_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[TIME_W] ? TIME_ALL_ONES : s[TIME_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/stq_front.sv -----
`default_nettype none
module stq_front
    import stq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          push_valid,
    input  wire logic     push_ready,
    output cmd_t          push_cmd
);

    localparam int unsigned CNT_W = $clog2(TIME_W);

    front_state_t      state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;

    logic [TIME_W-1:0] first;
    logic [TIME_W:0]   shifted;
    logic              need_div;

    assign push_valid = pend_reg;
    assign push_cmd   = cmd_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= F_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk) begin
        cmd_reg <= cmd_next;
        now_reg <= now_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd_next   = cmd_reg;
        now_next   = now_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        first      = sat_add(in_data.deadline, in_data.interval);
        need_div   = 1'b0;
        shifted    = {rem_reg, dvd_reg[TIME_W-1]};

        if (pend_reg && push_ready) begin
            pend_next = 1'b0;
        end

        unique case (state_reg)
            F_IDLE: begin
                in_ready = !pend_reg || push_ready;
                if (in_valid && in_ready) begin
                    cmd_next.kind   = kind_t'(in_data.kind);
                    cmd_next.id     = in_data.item_id;
                    cmd_next.period = in_data.interval;
                    now_next        = in_data.now;
                    // Rearm needs a division only when one period does not pass now.
                    need_div = (in_data.kind == KIND_REARM) &&
                               (in_data.interval != '0) &&
                               (first <= in_data.now) &&
                               (first != TIME_ALL_ONES);
                    if (in_data.kind == KIND_ARM) begin
                        cmd_next.dl = in_data.absolute ? in_data.deadline
                                      : sat_add(in_data.now, in_data.deadline);
                    end else if (in_data.kind == KIND_REARM) begin
                        cmd_next.dl = first;
                    end else begin
                        cmd_next.dl = in_data.deadline;
                    end
                    if (need_div) begin
                        dvd_next   = in_data.now - in_data.deadline;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = F_DIV;
                    end else begin
                        pend_next = 1'b1;
                    end
                end
            end
            F_DIV: begin
                // Restoring division, one bit a cycle; only the remainder is kept.
                if (shifted >= {1'b0, cmd_reg.period}) begin
                    shifted = shifted - {1'b0, cmd_reg.period};
                end
                rem_next = shifted[TIME_W-1:0];
                dvd_next = {dvd_reg[TIME_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == {CNT_W{1'b1}}) begin
                    state_next = F_BASE;
                end
            end
            F_BASE: begin
                // The last whole period at or before now lies at now minus the remainder.
                cmd_next.dl = now_reg - rem_reg;
                state_next  = F_ADD;
            end
            F_ADD: begin
                if (!pend_reg || push_ready) begin
                    cmd_next.dl = sat_add(cmd_reg.dl, cmd_reg.period);
                    pend_next   = 1'b1;
                    state_next  = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_DIV) |-> (cmd_reg.period != '0))
        else $error("division started with a zero period");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_BASE) |-> (rem_reg < cmd_reg.period))
        else $error("remainder not below period");

endmodule
`default_nettype wire

// ----- sv/stq_cmd_fifo.sv -----
`default_nettype none
module stq_cmd_fifo
    import stq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t       buf_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_cmd    = buf_reg[rp_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_push) begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            buf_reg[wp_reg] <= push_cmd;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("command queue count out of range");

endmodule
`default_nettype wire

// ----- sv/stq_back.sv -----
`default_nettype none
module stq_back
    import stq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pop_valid,
    output logic      pop_ready,
    input  wire cmd_t pop_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    slot_t mem [DEPTH];
    slot_t rd_data_reg;

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic [TIME_W-1:0] found_reg, found_next;
    out_item_t         res_reg, res_next;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic          we;
    logic [IW-1:0] wa, rd_addr;
    slot_t         wd, new_slot;
    logic          load_out;
    out_item_t     out_next;
    logic          out_free;
    logic [CW-1:0] i_dec, i_inc;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == B_IDLE);
    assign i_dec     = i_reg - CW'(1);
    assign i_inc     = i_reg + CW'(1);
    assign new_slot  = '{id: cmd_reg.id, dl: cmd_reg.dl, period: cmd_reg.period};

    always_ff @(posedge clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= B_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        cmd_reg   <= cmd_next;
        i_reg     <= i_next;
        found_reg <= found_next;
        res_reg   <= res_next;
        if (load_out) begin
            out_data_reg <= out_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        i_next     = i_reg;
        occ_next   = occ_reg;
        found_next = found_reg;
        res_next   = res_reg;
        we         = 1'b0;
        wa         = i_reg[IW-1:0];
        wd         = new_slot;
        rd_addr    = i_reg[IW-1:0];
        load_out   = 1'b0;
        out_next   = res_reg;

        unique case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    cmd_next = pop_cmd;
                    unique case (pop_cmd.kind)
                        KIND_ARM, KIND_REARM: begin
                            if (occ_reg == FULL_COUNT) begin
                                res_next   = '{status: ST_FULL, out_id: pop_cmd.id,
                                               out_deadline: pop_cmd.dl, last: 1'b1};
                                state_next = B_EMIT;
                            end else begin
                                i_next     = occ_reg;
                                state_next = B_INS_RD;
                            end
                        end
                        KIND_WITHDRAW: begin
                            i_next     = '0;
                            state_next = B_WD_RD;
                        end
                        KIND_DRAIN: begin
                            if (occ_reg == '0) begin
                                res_next   = '{status: ST_EMPTY, out_id: '0,
                                               out_deadline: '0, last: 1'b1};
                                state_next = B_EMIT;
                            end else begin
                                i_next     = '0;
                                state_next = B_DR_RD;
                            end
                        end
                        default: state_next = B_IDLE;
                    endcase
                end
            end
            B_INS_RD: begin
                if (i_reg == '0) begin
                    we         = 1'b1;
                    occ_next   = occ_reg + CW'(1);
                    res_next   = '{status: ST_DONE, out_id: cmd_reg.id,
                                   out_deadline: cmd_reg.dl, last: 1'b1};
                    state_next = B_EMIT;
                end else begin
                    rd_addr    = i_dec[IW-1:0];
                    state_next = B_INS_CMP;
                end
            end
            B_INS_CMP: begin
                // Walk down from the tail, moving later deadlines up one slot.
                we = 1'b1;
                if (rd_data_reg.dl > cmd_reg.dl) begin
                    wd         = rd_data_reg;
                    i_next     = i_dec;
                    state_next = B_INS_RD;
                end else begin
                    occ_next   = occ_reg + CW'(1);
                    res_next   = '{status: ST_DONE, out_id: cmd_reg.id,
                                   out_deadline: cmd_reg.dl, last: 1'b1};
                    state_next = B_EMIT;
                end
            end
            B_WD_RD: begin
                if (i_reg == occ_reg) begin
                    res_next   = '{status: ST_NOT_FOUND, out_id: cmd_reg.id,
                                   out_deadline: '0, last: 1'b1};
                    state_next = B_EMIT;
                end else begin
                    state_next = B_WD_CMP;
                end
            end
            B_WD_CMP: begin
                i_next = i_inc;
                if (rd_data_reg.id == cmd_reg.id) begin
                    found_next = rd_data_reg.dl;
                    state_next = B_SH_RD;
                end else begin
                    state_next = B_WD_RD;
                end
            end
            B_SH_RD: begin
                if (i_reg == occ_reg) begin
                    occ_next   = occ_reg - CW'(1);
                    res_next   = '{status: ST_DONE, out_id: cmd_reg.id,
                                   out_deadline: found_reg, last: 1'b1};
                    state_next = B_EMIT;
                end else begin
                    state_next = B_SH_WR;
                end
            end
            B_SH_WR: begin
                we         = 1'b1;
                wa         = i_dec[IW-1:0];
                wd         = rd_data_reg;
                i_next     = i_inc;
                state_next = B_SH_RD;
            end
            B_DR_RD: begin
                state_next = B_DR_EMIT;
            end
            B_DR_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_next = '{status: ST_DONE, out_id: rd_data_reg.id,
                                 out_deadline: rd_data_reg.dl,
                                 last: (i_inc == occ_reg)};
                    if (i_inc == occ_reg) begin
                        occ_next   = '0;
                        state_next = B_IDLE;
                    end else begin
                        i_next     = i_inc;
                        state_next = B_DR_RD;
                    end
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_COUNT)
        else $error("occupancy beyond depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WD_CMP || state_reg == B_SH_WR) |-> (i_reg < occ_reg))
        else $error("walk index past occupancy");

endmodule
`default_nettype wire

// ----- sv/sorted_timer_queue_core.sv -----
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid / in_ready   | in_item_t  (one timer request)
// out     | output    | out_valid / out_ready | out_item_t (one result, last marks the end)
//
// A request passes through the front end and the command queue before the queue engine.
// Arm there walks down from the tail, moving each later entry up one slot, then writes the new
// entry; withdraw scans for the id and moves each entry after it down one slot.
// Rearm goes through a one-bit-a-cycle remainder unit when one period does not pass now.
// Drain reads each entry through the registered read of the timer memory, then emits it.
// Reset clears control state and the occupancy; the timer memory itself is not cleared.
// A two-entry command queue lets the front end take a new request while the queue
// engine works or waits for out_ready.
`default_nettype none
module sorted_timer_queue_core
    import stq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_item_t     out_data
);

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    stq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    stq_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    stq_back #(.DEPTH(DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ----- tb/sv/sorted_timer_queue_core_test.sv -----
`default_nettype none
module sorted_timer_queue_core_test;
    import stq_pkg::*;

    localparam int unsigned QDEPTH = DEPTH_DEFAULT;
    localparam logic [63:0] INF = TIME_ALL_ONES;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    sorted_timer_queue_core #(.DEPTH(QDEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mirror of the queue contents.
    logic [7:0]  timer_id  [QDEPTH];
    logic [63:0] timer_due [QDEPTH];
    int unsigned timer_count;

    out_item_t   pending_words [$];
    int          error_count;
    bit          no_idle;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [63:0] dl;
        logic [63:0] iv;
        logic        absolute;
        logic [63:0] now;
        bit          typed;
        out_item_t   want;
    } row_t;

    function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? INF : s[63:0];
    endfunction

    function automatic logic [63:0] next_due(logic [63:0] d, logic [63:0] iv,
                                             logic [63:0] now);
        logic [63:0] first;
        logic [63:0] q;
        first = clamp_add(d, iv);
        if (iv == 64'd0 || first > now || first == INF)
            return first;
        q = (now - d) / iv;
        return clamp_add(d + q * iv, iv);
    endfunction

    function automatic out_item_t make_word(status_t st, logic [7:0] id,
                                            logic [63:0] dl, logic last);
        out_item_t w;
        w.status = st;
        w.out_id = id;
        w.out_deadline = dl;
        w.last = last;
        return w;
    endfunction

    task automatic predict_timer_queue(in_item_t req);
        logic [63:0] d;
        int unsigned pos;
        int          hit;
        case (kind_t'(req.kind))
            KIND_ARM, KIND_REARM:
            begin
                if (req.kind == KIND_ARM)
                    d = req.absolute ? req.deadline : clamp_add(req.now, req.deadline);
                else
                    d = next_due(req.deadline, req.interval, req.now);
                if (timer_count >= QDEPTH)
                    pending_words.push_back(make_word(ST_FULL, req.item_id, d, 1'b1));
                else
                begin
                    pos = 0;
                    while (pos < timer_count && timer_due[pos] <= d)
                        pos++;
                    for (int i = timer_count; i > pos; i--)
                    begin
                        timer_id[i] = timer_id[i-1];
                        timer_due[i] = timer_due[i-1];
                    end
                    timer_id[pos] = req.item_id;
                    timer_due[pos] = d;
                    timer_count++;
                    pending_words.push_back(make_word(ST_DONE, req.item_id, d, 1'b1));
                end
            end
            KIND_WITHDRAW:
            begin
                hit = -1;
                for (int i = 0; i < timer_count; i++)
                    if (hit < 0 && timer_id[i] == req.item_id)
                        hit = i;
                if (hit < 0)
                    pending_words.push_back(make_word(ST_NOT_FOUND, req.item_id, 64'd0, 1'b1));
                else
                begin
                    pending_words.push_back(make_word(ST_DONE, req.item_id,
                                                      timer_due[hit], 1'b1));
                    for (int i = hit; i + 1 < timer_count; i++)
                    begin
                        timer_id[i] = timer_id[i+1];
                        timer_due[i] = timer_due[i+1];
                    end
                    timer_count--;
                end
            end
            default:
            begin
                if (timer_count == 0)
                    pending_words.push_back(make_word(ST_EMPTY, 8'd0, 64'd0, 1'b1));
                for (int i = 0; i < timer_count; i++)
                    pending_words.push_back(make_word(ST_DONE, timer_id[i], timer_due[i],
                                                      i + 1 == timer_count));
                timer_count = 0;
            end
        endcase
    endtask

    task automatic send_word(in_item_t req, bit typed, out_item_t want);
        while (!no_idle && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        predict_timer_queue(req);
        // A typed row gives a single result, which stands in for the predicted word.
        if (typed)
            pending_words[$] = want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic: withdraw ids that are likely queued, deadlines near now.
    function automatic in_item_t random_request();
        in_item_t r;
        logic [63:0] base;
        int unsigned pick;
        base = {$urandom, $urandom};
        r.kind = $urandom_range(9) < 5 ? KIND_ARM : $urandom_range(2) == 0 ?
                 KIND_WITHDRAW : $urandom_range(3) == 0 ? KIND_DRAIN : KIND_REARM;
        r.item_id = $urandom_range(15) == 0 ? 8'($urandom) : 8'($urandom_range(23));
        r.absolute = 1'($urandom_range(1));
        r.now = base;
        pick = $urandom_range(4);
        case (pick)
            0: r.deadline = {$urandom, $urandom};
            1: r.deadline = INF;
            2: r.deadline = 64'($urandom_range(1000));
            default: r.deadline = base - 64'($urandom_range(5000));
        endcase
        pick = $urandom_range(5);
        case (pick)
            0: r.interval = {$urandom, $urandom};
            1: r.interval = INF;
            2: r.interval = 64'd0;
            default: r.interval = 64'($urandom_range(700) + 1);
        endcase
        if (r.absolute && r.kind == KIND_ARM && $urandom_range(1))
            r.deadline = base + 64'($urandom_range(50));
        return r;
    endfunction

    row_t rows[$];

    task automatic add_row(logic [1:0] k, logic [7:0] id, logic [63:0] dl, logic [63:0] iv,
                           logic ab, logic [63:0] now, bit typed, out_item_t want);
        row_t r;
        r.kind = k; r.id = id; r.dl = dl; r.iv = iv; r.absolute = ab; r.now = now;
        r.typed = typed; r.want = want;
        rows.push_back(r);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t: unexpected word %p", $time, out_data);
                    error_count++;
                end
                else if (pending_words[0] !== out_data)
                begin
                    $display("%0t: expected %p, got %p", $time, pending_words[0], out_data);
                    error_count++;
                    void'(pending_words.pop_front());
                end
                else
                    void'(pending_words.pop_front());
            end
            out_ready <= no_idle || $urandom_range(99) >= 37;
        end
    end

    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        in_item_t  req;
        out_item_t none;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        timer_count = 0;
        error_count = 0;
        no_idle = 1'b0;

        // Empty cases first, then the extremes of each field and operation, then a full queue and drain.
        add_row(KIND_DRAIN, 8'd7, 64'd0, 64'd0, 1'b0, 64'd0, 1,
                make_word(ST_EMPTY, 8'd0, 64'd0, 1'b1));
        add_row(KIND_WITHDRAW, 8'hFF, 64'd0, 64'd0, 1'b0, 64'd0, 1,
                make_word(ST_NOT_FOUND, 8'hFF, 64'd0, 1'b1));
        add_row(KIND_ARM, 8'd0, INF, 64'd0, 1'b1, 64'd0, 1,
                make_word(ST_DONE, 8'd0, INF, 1'b1));
        add_row(KIND_ARM, 8'hFF, 64'd0, INF, 1'b1, INF, 1,
                make_word(ST_DONE, 8'hFF, 64'd0, 1'b1));
        add_row(KIND_ARM, 8'd1, 64'd5, 64'd3, 1'b0, INF, 1,
                make_word(ST_DONE, 8'd1, INF, 1'b1));
        add_row(KIND_ARM, 8'd2, 64'd100, 64'd3, 1'b0, 64'd900, 0, none);
        add_row(KIND_ARM, 8'd3, 64'd1000, 64'd3, 1'b1, 64'd0, 0, none);
        add_row(KIND_REARM, 8'd4, 64'd10, 64'd0, 1'b0, 64'd500, 1,
                make_word(ST_DONE, 8'd4, 64'd10, 1'b1));
        add_row(KIND_REARM, 8'd5, 64'd10, 64'd7, 1'b0, 64'd500, 0, none);
        add_row(KIND_REARM, 8'd6, 64'd10, INF, 1'b0, 64'd500, 1,
                make_word(ST_DONE, 8'd6, INF, 1'b1));
        add_row(KIND_REARM, 8'd7, 64'd1, 64'd1, 1'b0, INF - 64'd1, 0, none);
        add_row(KIND_REARM, 8'd8, 64'd0, 64'h8000_0000_0000_0001, 1'b0, INF, 0, none);
        add_row(KIND_WITHDRAW, 8'd3, 64'd0, 64'd0, 1'b0, 64'd0, 1,
                make_word(ST_DONE, 8'd3, 64'd1000, 1'b1));
        add_row(KIND_DRAIN, 8'd0, 64'd0, 64'd0, 1'b0, 64'd0, 0, none);
        for (int i = 0; i < QDEPTH; i++)
            add_row(KIND_ARM, 8'(i), 64'd50, 64'd1, 1'b1, 64'd0, 0, none);
        add_row(KIND_ARM, 8'd99, 64'd1, 64'd0, 1'b0, 64'd2, 1,
                make_word(ST_FULL, 8'd99, 64'd3, 1'b1));
        add_row(KIND_REARM, 8'd98, 64'd1, 64'd0, 1'b0, 64'd2, 1,
                make_word(ST_FULL, 8'd98, 64'd1, 1'b1));
        add_row(KIND_DRAIN, 8'd0, 64'd0, 64'd0, 1'b0, 64'd0, 0, none);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            req.kind = rows[i].kind;
            req.item_id = rows[i].id;
            req.deadline = rows[i].dl;
            req.interval = rows[i].iv;
            req.absolute = rows[i].absolute;
            req.now = rows[i].now;
            send_word(req, rows[i].typed, rows[i].want);
        end

        for (int n = 0; n < 236; n++)
        begin
            no_idle = (n >= 100 && n < 150);
            send_word(random_request(), 1'b0, none);
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
